### rtl/core/modexp_pkg.sv
// Shared definitions for the modular exponentiation block.
// Depends on nothing; imported by modexp_mul_unit and modular_exponentiation.
`default_nettype none

package modexp_pkg;

   localparam int MODEXP_WORD_BITS = 32;
   localparam int CSR_INDEX_BITS   = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_EXPONENT = 1'b0,
      REG_MODULUS  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_STEP,
      ST_MUL_ACC,
      ST_MUL_SQ,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage

`default_nettype wire

### rtl/core/modexp_mul_unit.sv
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle, MSB first.
// Depends on modexp_pkg for the default word width and the status struct.
`default_nettype none

module modexp_mul_unit #(
   parameter int WORD_BITS = modexp_pkg::MODEXP_WORD_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [WORD_BITS-1:0]       a,
   input  wire logic [WORD_BITS-1:0]       b,
   input  wire logic [WORD_BITS-1:0]       m,
   output modexp_pkg::mul_status_type      status,
   output logic      [WORD_BITS-1:0]       result
);
   import modexp_pkg::*;

   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS-1:0] r_ff, r_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;

   logic [WORD_BITS:0]   dbl;
   logic [WORD_BITS:0]   dbl_sub;
   logic [WORD_BITS-1:0] dbl_red;
   logic [WORD_BITS:0]   sum;
   logic [WORD_BITS:0]   sum_sub;
   logic [WORD_BITS-1:0] sum_red;

   // Double, reduce, then add a when the current bit of b is set, reduce again.
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_sub = dbl - {1'b0, m};
      dbl_red = (dbl >= {1'b0, m}) ? dbl_sub[WORD_BITS-1:0] : dbl[WORD_BITS-1:0];
      sum     = {1'b0, dbl_red} + (b_ff[WORD_BITS-1] ? {1'b0, a_ff} : '0);
      sum_sub = sum - {1'b0, m};
      sum_red = (sum >= {1'b0, m}) ? sum_sub[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(WORD_BITS - 1);
         r_in    = '0;
         a_in    = a;
         b_in    = b;
      end else if (busy_ff) begin
         r_in   = sum_red;
         b_in   = {b_ff[WORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = r_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("multiplier done without a preceding busy cycle");
   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier done while still busy");
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("multiplier done held for more than one cycle");
`endif

endmodule

`default_nettype wire

### rtl/core/modular_exponentiation.sv
// Top level of the modular exponentiation block: registers, sequencer, result strobe.
// Depends on modexp_pkg and modexp_mul_unit.
// All multiplications, the base reduction included, run in turn on the one shared multiplier.
// Throughput: one transaction at a time; start is taken again in the cycle after the strobe.
// A modulus below two strobes its zero result in the cycle after acceptance.
// Reset (synchronous): sequencer to idle, exponent to 1, modulus to 2; no clearing pass.
// The result strobe lasts one cycle; the receiver cannot stall.
`default_nettype none

module modular_exponentiation #(
   parameter int WORD_BITS = modexp_pkg::MODEXP_WORD_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Request channel
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [WORD_BITS-1:0]                  req_base_value,
   // Response channel
   output logic                                       rsp_valid,
   output logic      [WORD_BITS-1:0]                  rsp_result_value,
   // Configuration port
   input  wire logic                                  csr_write_enable,
   input  wire logic [modexp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [WORD_BITS-1:0]                  csr_write_data
);
   import modexp_pkg::*;

   localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);
   localparam logic [WORD_BITS-1:0] TWO = WORD_BITS'(2);

   // Configuration registers
   logic [WORD_BITS-1:0] exponent_ff, exponent_in;
   logic [WORD_BITS-1:0] modulus_ff,  modulus_in;

   // Sequencer and working registers
   seq_state_type        state_ff, state_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in;   // exponent, shifted right one bit per step
   logic [WORD_BITS-1:0] acc_ff, acc_in;   // running product
   logic [WORD_BITS-1:0] sq_ff,  sq_in;    // base raised to successive powers of two

   // Shared multiplier hookup
   logic                 mul_start;
   logic [WORD_BITS-1:0] mul_a;
   logic [WORD_BITS-1:0] mul_b;
   mul_status_type       mul_status;
   logic [WORD_BITS-1:0] mul_result;

   logic                 accept;
   logic                 modulus_ok;

   assign accept     = start && (state_ff == ST_IDLE);
   assign modulus_ok = (modulus_ff >= TWO);

   // Configuration writes: decode the index, drop writes to unknown indexes.
   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            REG_EXPONENT: exponent_in = csr_write_data;
            REG_MODULUS:  modulus_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = modulus_ok ? ST_REDUCE : ST_DONE;
            end
         end
         ST_REDUCE: begin
            if (mul_status.done) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = ST_MUL_ACC;
            end else begin
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_ACC: begin
            if (mul_status.done) begin
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            if (mul_status.done) begin
               state_in = ST_STEP;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: multiplier launch, operand choice, register updates.
   always_comb begin
      mul_start = 1'b0;
      mul_a     = sq_ff;
      mul_b     = sq_ff;
      exp_in    = exp_ff;
      acc_in    = acc_ff;
      sq_in     = sq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               exp_in = exponent_ff;
               if (modulus_ok) begin
                  // Reduce the base as 1 * base mod m on the same multiplier.
                  mul_start = 1'b1;
                  mul_a     = ONE;
                  mul_b     = req_base_value;
                  acc_in    = ONE;
               end else begin
                  acc_in = '0;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_status.done) begin
               sq_in = mul_result;
            end
         end
         ST_STEP: begin
            if (exp_ff != '0) begin
               mul_start = 1'b1;
               mul_a     = exp_ff[0] ? acc_ff : sq_ff;
            end
         end
         ST_MUL_ACC: begin
            if (mul_status.done) begin
               acc_in    = mul_result;
               mul_start = 1'b1;   // chain straight into the squaring
            end
         end
         ST_MUL_SQ: begin
            if (mul_status.done) begin
               sq_in  = mul_result;
               exp_in = {1'b0, exp_ff[WORD_BITS-1:1]};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         exponent_ff <= ONE;
         modulus_ff  <= TWO;
      end else begin
         state_ff    <= state_in;
         exponent_ff <= exponent_in;
         modulus_ff  <= modulus_in;
      end
      exp_ff <= exp_in;
      acc_ff <= acc_in;
      sq_ff  <= sq_in;
   end

   modexp_mul_unit #(
      .WORD_BITS (WORD_BITS)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .m      (modulus_ff),
      .status (mul_status),
      .result (mul_result)
   );

   // Hold the result on the ports for the single strobe cycle.
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_result_value = acc_ff;

`ifndef SYNTHESIS
   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (modulus_ok ? (rsp_result_value < modulus_ff) : (rsp_result_value == '0)))
      else $error("result not reduced by the modulus");
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (acc_ff < modulus_ff) && (sq_ff < modulus_ff))
      else $error("working value escaped the modulus");
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_status.done |->
         (state_ff == ST_REDUCE) || (state_ff == ST_MUL_ACC) || (state_ff == ST_MUL_SQ))
      else $error("multiplier finished while the sequencer was not waiting");
   a_no_launch_while_busy: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_status.busy)
      else $error("multiplier launched while still busy");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire
